### sv/hrtw_pkg.sv
// ----------------------------------------------------------------------------
// hrtw_pkg: shared types and constants of the hierarchical timer wheel
// transfer structs, result codes, list sentinel and shift helper
// ----------------------------------------------------------------------------
package hrtw_pkg;

  localparam int unsigned NEAR_BITS_DEF    = 8;
  localparam int unsigned LEVEL_BITS_DEF   = 6;
  localparam int unsigned POOL_ENTRIES_DEF = 64;
  localparam int unsigned NUM_LEVELS       = 4;
  localparam int unsigned TOP_LEVEL        = 3;

  typedef logic [6:0] ptr_t;
  localparam ptr_t PTR_NONE = 7'd127;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DELAY = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        handle;
    logic signed [31:0] delay;
    logic signed [31:0] session;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        out_handle;
    logic signed [31:0] out_session;
    logic [1:0]         status;
    logic               last;
  } res_t;

  // logical right shift that yields zero once the whole word is shifted out
  function automatic logic [31:0] shr32(input logic [31:0] x, input int unsigned s);
    logic [31:0] r;
    r = (s >= 32) ? 32'd0 : (x >> s);
    return r;
  endfunction

endpackage

### sv/hrtw_place.sv
// ----------------------------------------------------------------------------
// hrtw_place: slot selection unit
// picks the wheel slot for an expiry from the highest differing bit group
// ----------------------------------------------------------------------------
module hrtw_place #(
  parameter int unsigned NEAR_BITS  = hrtw_pkg::NEAR_BITS_DEF,
  parameter int unsigned LEVEL_BITS = hrtw_pkg::LEVEL_BITS_DEF,
  parameter int unsigned SW         = 9
) (
  input  logic [31:0]   expiry_i,
  input  logic [31:0]   tick_i,
  output logic [SW-1:0] slot_o
);
  import hrtw_pkg::*;

  localparam int unsigned NEAR_SLOTS  = 1 << NEAR_BITS;
  localparam int unsigned LEVEL_SLOTS = 1 << LEVEL_BITS;

  logic        found;
  logic [1:0]  lvl;
  logic [31:0] idx;

  always_comb begin
    found = 1'b0;
    lvl   = 2'(TOP_LEVEL);
    for (int unsigned l = 0; l < TOP_LEVEL; l++) begin
      if (!found && shr32(expiry_i, NEAR_BITS + (l + 1) * LEVEL_BITS)
                    == shr32(tick_i, NEAR_BITS + (l + 1) * LEVEL_BITS)) begin
        found = 1'b1;
        lvl   = 2'(l);
      end
    end
    idx = shr32(expiry_i, NEAR_BITS + 32'(lvl) * LEVEL_BITS) & 32'(LEVEL_SLOTS - 1);
    if (shr32(expiry_i, NEAR_BITS) == shr32(tick_i, NEAR_BITS)) begin
      slot_o = SW'(expiry_i & 32'(NEAR_SLOTS - 1));
    end else begin
      slot_o = SW'(32'(NEAR_SLOTS) + 32'(lvl) * 32'(LEVEL_SLOTS) + idx);
    end
  end

endmodule

### sv/hierarchical_timer_wheel.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel: five-level timer wheel with a shared list sequencer
// near wheel plus four outer wheels of FIFO slot lists over a bounded pool
// ----------------------------------------------------------------------------
// usage
//   request channel: drive req_i and raise start; a transfer happens at a
//   clock edge with start high and busy low. busy stays high until the last
//   result of that request is on the result ports.
//   result channel: res_valid_o strobes for one cycle per result; the receiver
//   must take it then, it cannot stall the block.
//   add request: on error the acknowledge is on the ports in the cycle right
//   after the transfer; on success busy is high through S_ADD_NX, S_PLC_A and
//   S_PLC_B, and the acknowledge is on the ports in the cycle busy falls.
//   tick: walks the current near slot (S_EXP_C and S_EXP_D per expired timer),
//   advances time, re-files one outer slot when a wheel boundary is crossed
//   (S_CAS_C, S_CAS_D, S_PLC_A and S_PLC_B per timer), walks the near slot
//   again. A tick with nothing due gives no result. The last result of a
//   request carries last = 1. The sequencer shares one slot selection unit
//   and list memories with one read and one write port each; their reads are
//   registered. After reset the block runs a clearing pass over every slot
//   head and pool entry with busy high before the first transfer.
module hierarchical_timer_wheel #(
  parameter int unsigned NEAR_BITS    = hrtw_pkg::NEAR_BITS_DEF,
  parameter int unsigned LEVEL_BITS   = hrtw_pkg::LEVEL_BITS_DEF,
  parameter int unsigned POOL_ENTRIES = hrtw_pkg::POOL_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hrtw_pkg::req_t req_i,
  output logic           res_valid_o,
  output hrtw_pkg::res_t res_o
);
  import hrtw_pkg::*;

  localparam int unsigned NEAR_SLOTS  = 1 << NEAR_BITS;
  localparam int unsigned LEVEL_SLOTS = 1 << LEVEL_BITS;
  localparam int unsigned TOTAL_SLOTS = NEAR_SLOTS + NUM_LEVELS * LEVEL_SLOTS;
  localparam int unsigned SW          = $clog2(TOTAL_SLOTS);
  localparam int unsigned EW          = $clog2(POOL_ENTRIES);
  localparam int unsigned CLR_N       = (TOTAL_SLOTS > POOL_ENTRIES) ? TOTAL_SLOTS
                                                                     : POOL_ENTRIES;
  localparam int unsigned CW          = $clog2(CLR_N);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CLR    = 14'b00000000000010,
    S_ADD_NX = 14'b00000000000100,
    S_PLC_A  = 14'b00000000001000,
    S_PLC_B  = 14'b00000000010000,
    S_EXP_A  = 14'b00000000100000,
    S_EXP_B  = 14'b00000001000000,
    S_EXP_C  = 14'b00000010000000,
    S_EXP_D  = 14'b00000100000000,
    S_CAS_A  = 14'b00001000000000,
    S_CAS_B  = 14'b00010000000000,
    S_CAS_C  = 14'b00100000000000,
    S_CAS_D  = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [31:0]   tick_q, tick_d;
  ptr_t          free_q, free_d;
  ptr_t          cur_q, cur_d;
  ptr_t          nx_q, nx_d;
  logic [31:0]   exp_q, exp_d;
  logic          phase_q, phase_d;
  logic          from_add_q, from_add_d;
  logic [SW-1:0] slot_q, slot_d;
  logic          pend_v_q, pend_v_d;
  res_t          pend_q, pend_d;
  logic          res_v_q, res_v_d;
  res_t          res_q, res_d;
  req_t          req_q, req_d;

  // list memories, registered read
  ptr_t          head_mem [TOTAL_SLOTS];
  logic [EW-1:0] tail_mem [TOTAL_SLOTS];
  ptr_t          next_mem [POOL_ENTRIES];
  logic [31:0]   hdl_mem  [POOL_ENTRIES];
  logic [31:0]   ses_mem  [POOL_ENTRIES];
  logic [31:0]   xp_mem   [POOL_ENTRIES];

  logic          h_we;
  logic [SW-1:0] h_wa, h_ra;
  ptr_t          h_wd, h_rd;
  logic          t_we;
  logic [SW-1:0] t_wa, t_ra;
  logic [EW-1:0] t_wd, t_rd;
  logic          n_we;
  logic [EW-1:0] n_wa, n_ra;
  ptr_t          n_wd, n_rd;
  logic          e_we;
  logic [EW-1:0] e_wa, e_ra;
  logic [31:0]   e_hdl_wd, e_ses_wd, e_xp_wd;
  logic [31:0]   hdl_rd, ses_rd, xp_rd;

  always_ff @(posedge clk_i) begin
    h_rd <= head_mem[h_ra];
    if (h_we) begin
      head_mem[h_wa] <= h_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    t_rd <= tail_mem[t_ra];
    if (t_we) begin
      tail_mem[t_wa] <= t_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    n_rd <= next_mem[n_ra];
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    hdl_rd <= hdl_mem[e_ra];
    ses_rd <= ses_mem[e_ra];
    xp_rd  <= xp_mem[e_ra];
    if (e_we) begin
      hdl_mem[e_wa] <= e_hdl_wd;
      ses_mem[e_wa] <= e_ses_wd;
      xp_mem[e_wa]  <= e_xp_wd;
    end
  end

  // shared slot selection for every filing of an entry
  logic [SW-1:0] plc_slot;

  hrtw_place #(
    .NEAR_BITS  (NEAR_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .SW         (SW)
  ) u_place (
    .expiry_i (exp_q),
    .tick_i   (tick_q),
    .slot_o   (plc_slot)
  );

  // cascade target for the tick after the current one
  logic [31:0]   ct;
  logic          cas_en;
  logic [SW-1:0] cas_slot;
  logic          cas_stop;
  logic [31:0]   cas_idx;

  always_comb begin
    ct       = tick_q + 32'd1;
    cas_en   = 1'b0;
    cas_stop = 1'b0;
    cas_slot = SW'(NEAR_SLOTS + TOP_LEVEL * LEVEL_SLOTS);
    cas_idx  = 32'd0;
    if (ct == 32'd0) begin
      cas_en = 1'b1;
    end else begin
      for (int unsigned l = 0; l < NUM_LEVELS; l++) begin
        if (!cas_stop) begin
          // lower bits not all zero: no boundary at this level
          if ((NEAR_BITS + l * LEVEL_BITS) >= 32 ||
              (shr32(ct, NEAR_BITS + l * LEVEL_BITS) << (NEAR_BITS + l * LEVEL_BITS))
                != ct) begin
            cas_stop = 1'b1;
          end else begin
            cas_idx = shr32(ct, NEAR_BITS + l * LEVEL_BITS) & 32'(LEVEL_SLOTS - 1);
            if (cas_idx != 32'd0) begin
              cas_en   = 1'b1;
              cas_stop = 1'b1;
              cas_slot = SW'(NEAR_SLOTS + l * LEVEL_SLOTS) + SW'(cas_idx);
            end
          end
        end
      end
    end
  end

  localparam logic [31:0] NEAR_MASK = 32'(NEAR_SLOTS - 1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    tick_d     = tick_q;
    free_d     = free_q;
    cur_d      = cur_q;
    nx_d       = nx_q;
    exp_d      = exp_q;
    phase_d    = phase_q;
    from_add_d = from_add_q;
    slot_d     = slot_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    req_d      = req_q;

    h_we = 1'b0; h_wa = slot_q; h_wd = PTR_NONE; h_ra = slot_q;
    t_we = 1'b0; t_wa = slot_q; t_wd = cur_q[EW-1:0]; t_ra = plc_slot;
    n_we = 1'b0; n_wa = cur_q[EW-1:0]; n_wd = PTR_NONE; n_ra = cur_q[EW-1:0];
    e_we = 1'b0; e_wa = free_q[EW-1:0]; e_ra = cur_q[EW-1:0];
    e_hdl_wd = req_i.handle;
    e_ses_wd = req_i.session;
    e_xp_wd  = tick_q + req_i.delay;

    case (state_q)
      S_CLR: begin
        if (32'(clr_q) < TOTAL_SLOTS) begin
          h_we = 1'b1;
          h_wa = SW'(clr_q);
        end
        if (32'(clr_q) < POOL_ENTRIES) begin
          n_we = 1'b1;
          n_wa = EW'(clr_q);
          n_wd = (32'(clr_q) + 1 < POOL_ENTRIES) ? ptr_t'(32'(clr_q) + 1) : PTR_NONE;
        end
        clr_d = clr_q + CW'(1);
        if (32'(clr_q) == CLR_N - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.req_type == REQ_TICK) begin
            phase_d = 1'b0;
            slot_d  = SW'(tick_q & NEAR_MASK);
            state_d = S_EXP_A;
          end else if (req_i.delay == 32'sd0 || req_i.delay[31]) begin
            res_v_d = 1'b1;
            res_d   = '{kind: KIND_ACK, out_handle: '0, out_session: '0,
                        status: ST_BAD_DELAY, last: 1'b1};
          end else if (free_q == PTR_NONE) begin
            res_v_d = 1'b1;
            res_d   = '{kind: KIND_ACK, out_handle: '0, out_session: '0,
                        status: ST_POOL_FULL, last: 1'b1};
          end else begin
            // claim the free head and store the timer fields
            cur_d      = free_q;
            n_ra       = free_q[EW-1:0];
            e_we       = 1'b1;
            exp_d      = tick_q + req_i.delay;
            from_add_d = 1'b1;
            state_d    = S_ADD_NX;
          end
        end
      end

      S_ADD_NX: begin
        free_d  = n_rd;
        state_d = S_PLC_A;
      end

      S_PLC_A: begin
        h_ra    = plc_slot;
        slot_d  = plc_slot;
        n_we    = 1'b1;
        state_d = S_PLC_B;
      end

      S_PLC_B: begin
        if (h_rd == PTR_NONE) begin
          h_we = 1'b1;
          h_wd = cur_q;
        end else begin
          n_we = 1'b1;
          n_wa = t_rd;
          n_wd = cur_q;
        end
        t_we = 1'b1;
        if (from_add_q) begin
          res_v_d = 1'b1;
          res_d   = '{kind: KIND_ACK, out_handle: '0, out_session: req_q.session,
                      status: ST_OK, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          cur_d   = nx_q;
          state_d = S_CAS_C;
        end
      end

      S_EXP_A: begin
        state_d = S_EXP_B;
      end

      S_EXP_B: begin
        cur_d   = h_rd;
        state_d = S_EXP_C;
      end

      S_EXP_C: begin
        if (cur_q != PTR_NONE) begin
          state_d = S_EXP_D;
        end else if (!phase_q) begin
          tick_d  = ct;
          phase_d = 1'b1;
          if (cas_en) begin
            slot_d  = cas_slot;
            state_d = S_CAS_A;
          end else begin
            slot_d  = SW'(ct & NEAR_MASK);
            state_d = S_EXP_A;
          end
        end else begin
          if (pend_v_q) begin
            res_v_d      = 1'b1;
            res_d        = pend_q;
            res_d.last   = 1'b1;
            pend_v_d     = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      S_EXP_D: begin
        // unlink from the slot and return to the free list
        h_we = 1'b1;
        h_wd = n_rd;
        n_we = 1'b1;
        n_wd = free_q;
        free_d = cur_q;
        cur_d  = n_rd;
        if (pend_v_q) begin
          res_v_d = 1'b1;
          res_d   = pend_q;
        end
        pend_v_d = 1'b1;
        pend_d   = '{kind: KIND_EXPIRE, out_handle: hdl_rd, out_session: ses_rd,
                     status: ST_OK, last: 1'b0};
        state_d  = S_EXP_C;
      end

      S_CAS_A: begin
        h_we    = 1'b1;
        state_d = S_CAS_B;
      end

      S_CAS_B: begin
        cur_d   = h_rd;
        state_d = S_CAS_C;
      end

      S_CAS_C: begin
        if (cur_q != PTR_NONE) begin
          state_d = S_CAS_D;
        end else begin
          slot_d  = SW'(tick_q & NEAR_MASK);
          state_d = S_EXP_A;
        end
      end

      S_CAS_D: begin
        nx_d       = n_rd;
        exp_d      = xp_rd;
        from_add_d = 1'b0;
        state_d    = S_PLC_A;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      tick_q   <= '0;
      free_q   <= '0;
      phase_q  <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      tick_q   <= tick_d;
      free_q   <= free_d;
      phase_q  <= phase_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nx_q       <= nx_d;
    exp_q      <= exp_d;
    from_add_q <= from_add_d;
    slot_q     <= slot_d;
    pend_q     <= pend_d;
    res_q      <= res_d;
    req_q      <= req_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_free_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (free_q == PTR_NONE || 32'(free_q) < POOL_ENTRIES))
    else $error("free list head out of range");
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("expired timer held back at idle");
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_ACK) |-> res_o.last)
    else $error("acknowledge without last");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == REQ_TICK) |=> busy)
    else $error("tick transfer did not start the sequencer");
`endif

endmodule
